FILE: rtl/ftda_pkg.sv
// Shared types and constants for the float to decimal text formatter.
package ftda_pkg;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  // Classified item handed from the front end to the back end
  typedef struct packed {
    logic        err;
    logic        neg;
    logic [30:0] whole;
    logic [23:0] frac;
    logic [7:0]  shift;
  } ftda_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FRAC,
    ST_IDIG,
    ST_SIGN,
    ST_EMIT
  } ftda_state_t;

endpackage

FILE: rtl/ftda_front.sv
// Front end: decodes the IEEE single value into integer and fraction parts.
module ftda_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [31:0]          value_bits,
  output logic                 q_valid,
  input  logic                 q_ready,
  output ftda_pkg::ftda_item_t q_item
);

  logic                 full;
  ftda_pkg::ftda_item_t item;
  ftda_pkg::ftda_item_t item_next;
  logic [7:0]           expo;
  logic [23:0]          sig;
  logic [7:0]           rsh;
  logic [54:0]          wide;

  assign expo = value_bits[30:23];
  assign sig  = (expo == 8'd0) ? {1'b0, value_bits[22:0]} : {1'b1, value_bits[22:0]};

  // Right shift amount for exponent below the binary point (150 - e, or 149 for a zero exponent)
  always_comb begin
    item_next = '0;
    rsh = (expo == 8'd0) ? 8'd149 : 8'(8'd150 - expo);
    wide = '0;
    item_next.neg = value_bits[31] && (value_bits[30:0] != 31'd0);
    if (expo >= 8'd158) begin
      item_next.err = 1'b1;
    end else if (expo >= 8'd150) begin
      wide = {31'd0, sig} << (expo - 8'd150);
      item_next.whole = wide[30:0];
    end else if (rsh < 8'd32) begin
      item_next.whole = 31'({7'd0, sig} >> rsh);
      item_next.frac  = sig & 24'((32'd1 << rsh) - 32'd1);
      item_next.shift = rsh;
    end else begin
      item_next.frac  = sig;
      item_next.shift = rsh;
    end
  end

  // One-entry queue register
  assign in_ready = !full || q_ready;
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_ready) begin
      full <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= item_next;
    end
  end

  assign q_valid = full;
  assign q_item  = item;

endmodule

FILE: rtl/ftda_back.sv
// Back end: produces fraction and integer digits, then emits the characters.
module ftda_back #(
  parameter int FRACTION_DIGITS = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  ftda_pkg::ftda_item_t q_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           char_code,
  output logic                 last,
  output logic                 out_of_range
);

  localparam int TMAX = 12 + FRACTION_DIGITS;
  localparam int NW   = $clog2(TMAX + 1);
  localparam int FW   = $clog2(FRACTION_DIGITS + 1);

  ftda_pkg::ftda_state_t state, state_next;
  ftda_pkg::ftda_item_t  cur;
  logic [7:0]  text [TMAX];
  logic [NW-1:0] n, keep, pos;
  logic [FW-1:0] fcnt;
  logic [63:0] fr;
  logic [3:0]  fdigs [FRACTION_DIGITS];
  logic [30:0] whole;
  logic [3:0]  idigs [10];
  logic [3:0]  icnt;
  logic [67:0] fr10;
  logic [67:0] ftmp;
  logic [3:0]  fd;
  logic [30:0] wq;
  logic [3:0]  wr;

  // Multiply remaining fraction by ten; the digit is the part above the point
  always_comb begin
    fr10 = {4'd0, fr} * 68'd10;
    ftmp = fr10 >> cur.shift;
    fd   = ftmp[3:0];
  end

  // Divide by ten by reciprocal multiply; the remainder gives the digit
  always_comb begin
    logic [63:0] m;
    logic [34:0] r;
    m  = {33'd0, whole} * 64'hCCCC_CCCD;
    wq = 31'(m >> 35);
    r  = {4'd0, whole} - {4'd0, wq} * 35'd10;
    wr = r[3:0];
  end

  assign q_ready = (state == ftda_pkg::ST_IDLE);

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      ftda_pkg::ST_IDLE: if (q_valid) state_next = q_item.err ? ftda_pkg::ST_EMIT
                                                               : ftda_pkg::ST_FRAC;
      ftda_pkg::ST_FRAC: if (fcnt == FW'(FRACTION_DIGITS - 1)) state_next = ftda_pkg::ST_IDIG;
      ftda_pkg::ST_IDIG: if (wq == 31'd0 || icnt == 4'd9) state_next = ftda_pkg::ST_SIGN;
      ftda_pkg::ST_SIGN: state_next = ftda_pkg::ST_EMIT;
      ftda_pkg::ST_EMIT: if (out_ready && (cur.err || pos == keep - NW'(1)))
        state_next = ftda_pkg::ST_IDLE;
      default: state_next = ftda_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ftda_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ftda_pkg::ST_IDLE: begin
        cur   <= q_item;
        fr    <= {40'd0, q_item.frac};
        whole <= q_item.whole;
        fcnt  <= '0;
        icnt  <= '0;
        pos   <= '0;
      end
      ftda_pkg::ST_FRAC: begin
        fdigs[fcnt] <= (cur.shift == 8'd0) ? 4'd0 : fd;
        fr   <= (cur.shift == 8'd0) ? 64'd0 : 64'(fr10 & ((68'd1 << cur.shift) - 68'd1));
        fcnt <= fcnt + FW'(1);
      end
      ftda_pkg::ST_IDIG: begin
        idigs[icnt] <= wr;
        whole <= wq;
        if (!(wq == 31'd0 || icnt == 4'd9)) icnt <= icnt + 4'd1;
      end
      ftda_pkg::ST_SIGN: begin
        // Assemble text and trim trailing zeros
        logic [NW-1:0] k;
        logic [NW-1:0] fstart;
        logic [NW-1:0] kp;
        logic          trimming;
        k = '0;
        if (cur.neg) begin
          text[k] <= ftda_pkg::CH_MINUS;
          k = k + NW'(1);
        end
        for (int i = 9; i >= 0; i--) begin
          if (4'(i) <= icnt) begin
            text[k] <= ftda_pkg::CH_ZERO + {4'd0, idigs[i]};
            k = k + NW'(1);
          end
        end
        text[k] <= ftda_pkg::CH_DOT;
        k = k + NW'(1);
        fstart = k;
        for (int i = 0; i < FRACTION_DIGITS; i++) begin
          text[k] <= ftda_pkg::CH_ZERO + {4'd0, fdigs[i]};
          k = k + NW'(1);
        end
        trimming = 1'b1;
        kp = fstart + NW'(1);
        for (int i = FRACTION_DIGITS - 1; i >= 1; i--) begin
          if (trimming && fdigs[i] != 4'd0) begin
            kp = fstart + NW'(i + 1);
            trimming = 1'b0;
          end
        end
        keep <= kp;
        n <= k;
      end
      ftda_pkg::ST_EMIT: if (out_ready) pos <= pos + NW'(1);
      default: ;
    endcase
  end

  assign out_valid    = (state == ftda_pkg::ST_EMIT);
  assign char_code    = cur.err ? 8'd0 : text[pos];
  assign last         = cur.err || (pos == keep - NW'(1));
  assign out_of_range = cur.err;

`ifndef SYNTH
  a_err_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |-> last) else $error("error result not last");
  a_keep_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_of_range |-> keep <= n) else $error("trim beyond text");
  a_no_accept: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !q_ready) else $error("accept while emitting");
`endif

endmodule

FILE: rtl/float_to_decimal_ascii.sv
// Top level: IEEE single to fixed-point decimal ASCII text formatter.
// Steps for an in-range value: the front register, a handoff in the idle state, then
// FRACTION_DIGITS fraction steps, up to 10 integer digit steps and one assembly step
// before the first character. Output: one character per cycle while m_tready is high,
// up to FRACTION_DIGITS+12 per item; the next item is taken after the last character.
// Reset: rst synchronous active high clears queue and sequencer state.
module float_to_decimal_ascii #(
  parameter int FRACTION_DIGITS = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value_bits
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] char_code
  output logic        m_tlast,
  output logic        m_tuser    // [0] out_of_range
);

  logic                 q_valid;
  logic                 q_ready;
  ftda_pkg::ftda_item_t q_item;

  ftda_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready), .value_bits(s_tdata),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  ftda_back #(.FRACTION_DIGITS(FRACTION_DIGITS)) u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .char_code(m_tdata), .last(m_tlast), .out_of_range(m_tuser)
  );

endmodule
